// ----- rtl/ppi_pkg.sv -----
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, widths and helpers for the plane-plane intersection unit.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam int NormW = 16;
   localparam int OffW  = 32;
   localparam int DirW  = 33;
   localparam int DotW  = 33;
   localparam int DetW  = 64;
   localparam int NumW  = 65;
   localparam int ProdW = 82;
   localparam int OrgW  = 48;
   localparam int TolW  = 41;
   localparam int QuoW  = 48;

   // the two plane normals, three components each
   typedef struct packed {
      logic signed [NormW-1:0] ax;
      logic signed [NormW-1:0] ay;
      logic signed [NormW-1:0] az;
      logic signed [NormW-1:0] bx;
      logic signed [NormW-1:0] by;
      logic signed [NormW-1:0] bz;
   } ppi_norm_type;

   // classified item handed from the front part to the back part
   typedef struct packed {
      logic                   line;
      logic signed [DirW-1:0] dir_x;
      logic signed [DirW-1:0] dir_y;
      logic signed [DirW-1:0] dir_z;
      logic [DetW-1:0]        det;
      logic signed [NumW-1:0] num0;
      logic signed [NumW-1:0] num1;
      ppi_norm_type           norm;
   } ppi_item_type;

   // per-axis divider state
   typedef struct packed {
      logic [DetW-1:0] rem;
      logic [QuoW-1:0] num;
      logic [QuoW-1:0] quo;
      logic            neg;
      logic            ovf;
   } ppi_div_type;

   // sidecar that travels beside the divider
   typedef struct packed {
      logic                   vld;
      logic                   line;
      logic signed [DirW-1:0] dir_x;
      logic signed [DirW-1:0] dir_y;
      logic signed [DirW-1:0] dir_z;
      logic [DetW-1:0]        det;
   } ppi_side_type;

   // queue status seen by the top level
   typedef struct packed {
      logic not_empty;
      logic full;
   } ppi_q_stat_type;

   // saturate a sign-magnitude quotient to the signed origin range
   function automatic logic [OrgW-1:0] origin_sat(input logic neg, input logic ovf,
                                                  input logic [QuoW-1:0] q);
      logic [QuoW-1:0] lim;
      logic [QuoW-1:0] mag;
      lim = neg ? (QuoW'(1) << (OrgW-1)) : ((QuoW'(1) << (OrgW-1)) - QuoW'(1));
      mag = (ovf || (q > lim)) ? lim : q;
      return neg ? OrgW'(QuoW'(0) - mag) : OrgW'(mag);
   endfunction

endpackage

// ----- rtl/ppi_front.sv -----
// ----------------------------------------------------------------------------
// ppi_front
// Front part: cross product, dot products, determinant and numerators;
// classifies each pair as a line or as parallel planes.
// ----------------------------------------------------------------------------
module ppi_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  ppi_pkg::ppi_norm_type             norm,
   input  logic signed [ppi_pkg::OffW-1:0]   offset_a,
   input  logic signed [ppi_pkg::OffW-1:0]   offset_b,
   input  logic [ppi_pkg::TolW-1:0]          det_tolerance,
   output logic                              push,
   output ppi_pkg::ppi_item_type             item
);

   // stage 1: single products
   logic                                  v1_ff;
   ppi_pkg::ppi_norm_type                 n1_ff;
   logic signed [ppi_pkg::OffW-1:0]       d0_1_ff, d1_1_ff;
   logic signed [31:0] ay_bz_ff, az_by_ff, az_bx_ff, ax_bz_ff, ax_by_ff, ay_bx_ff;
   logic signed [31:0] ax_ax_ff, ay_ay_ff, az_az_ff, bx_bx_ff, by_by_ff, bz_bz_ff;
   logic signed [31:0] ax_bx_ff, ay_by_ff, az_bz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
      n1_ff    <= norm;
      d0_1_ff  <= offset_a;
      d1_1_ff  <= offset_b;
      ay_bz_ff <= norm.ay * norm.bz;
      az_by_ff <= norm.az * norm.by;
      az_bx_ff <= norm.az * norm.bx;
      ax_bz_ff <= norm.ax * norm.bz;
      ax_by_ff <= norm.ax * norm.by;
      ay_bx_ff <= norm.ay * norm.bx;
      ax_ax_ff <= norm.ax * norm.ax;
      ay_ay_ff <= norm.ay * norm.ay;
      az_az_ff <= norm.az * norm.az;
      bx_bx_ff <= norm.bx * norm.bx;
      by_by_ff <= norm.by * norm.by;
      bz_bz_ff <= norm.bz * norm.bz;
      ax_bx_ff <= norm.ax * norm.bx;
      ay_by_ff <= norm.ay * norm.by;
      az_bz_ff <= norm.az * norm.bz;
   end

   // stage 2: cross product and dot products
   logic                                  v2_ff;
   ppi_pkg::ppi_norm_type                 n2_ff;
   logic signed [ppi_pkg::OffW-1:0]       d0_2_ff, d1_2_ff;
   logic signed [ppi_pkg::DirW-1:0]       cx_ff, cy_ff, cz_ff;
   logic signed [ppi_pkg::DotW-1:0]       n00_ff, n01_ff, n11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      n2_ff   <= n1_ff;
      d0_2_ff <= d0_1_ff;
      d1_2_ff <= d1_1_ff;
      cx_ff   <= 33'(ay_bz_ff) - 33'(az_by_ff);
      cy_ff   <= 33'(az_bx_ff) - 33'(ax_bz_ff);
      cz_ff   <= 33'(ax_by_ff) - 33'(ay_bx_ff);
      n00_ff  <= 33'(ax_ax_ff) + 33'(ay_ay_ff) + 33'(az_az_ff);
      n01_ff  <= 33'(ax_bx_ff) + 33'(ay_by_ff) + 33'(az_bz_ff);
      n11_ff  <= 33'(bx_bx_ff) + 33'(by_by_ff) + 33'(bz_bz_ff);
   end

   // stage 3: squares and numerator products
   logic signed [65:0] sqx, sqy, sqz;
   logic                                  v3_ff;
   ppi_pkg::ppi_norm_type                 n3_ff;
   logic signed [ppi_pkg::DirW-1:0]       cx3_ff, cy3_ff, cz3_ff;
   logic [63:0]                           sqx_ff, sqy_ff, sqz_ff;
   logic signed [ppi_pkg::NumW-1:0]       m11d0_ff, m01d1_ff, m00d1_ff, m01d0_ff;

   assign sqx = 66'(cx_ff) * 66'(cx_ff);
   assign sqy = 66'(cy_ff) * 66'(cy_ff);
   assign sqz = 66'(cz_ff) * 66'(cz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      n3_ff    <= n2_ff;
      cx3_ff   <= cx_ff;
      cy3_ff   <= cy_ff;
      cz3_ff   <= cz_ff;
      sqx_ff   <= sqx[63:0];
      sqy_ff   <= sqy[63:0];
      sqz_ff   <= sqz[63:0];
      m11d0_ff <= n11_ff * d0_2_ff;
      m01d1_ff <= n01_ff * d1_2_ff;
      m00d1_ff <= n00_ff * d1_2_ff;
      m01d0_ff <= n01_ff * d0_2_ff;
   end

   // stage 4: determinant, numerators and classification
   logic [ppi_pkg::DetW-1:0] det_in;
   logic                     v4_ff;
   ppi_pkg::ppi_item_type    item_ff;

   assign det_in = sqx_ff + sqy_ff + sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      item_ff.line  <= (det_in != '0) && (det_in >= 64'(det_tolerance));
      item_ff.dir_x <= cx3_ff;
      item_ff.dir_y <= cy3_ff;
      item_ff.dir_z <= cz3_ff;
      item_ff.det   <= det_in;
      item_ff.num0  <= m11d0_ff - m01d1_ff;
      item_ff.num1  <= m00d1_ff - m01d0_ff;
      item_ff.norm  <= n3_ff;
   end

   assign push = v4_ff;
   assign item = item_ff;

endmodule

// ----- rtl/ppi_fifo.sv -----
// ----------------------------------------------------------------------------
// ppi_fifo
// Two-entry queue between the front and back parts, head shown directly.
// ----------------------------------------------------------------------------
module ppi_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ppi_pkg::ppi_item_type    push_item,
   input  logic                     pop,
   output ppi_pkg::ppi_item_type    head,
   output ppi_pkg::ppi_q_stat_type  stat
);

   ppi_pkg::ppi_item_type entry_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       do_pop;

   assign do_pop = pop && (count_ff != 2'd0);

   // storage
   always_ff @(posedge clock) begin
      if (push && (count_ff != 2'd2)) begin
         entry_ff[wptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push && (count_ff != 2'd2)) wptr_ff <= ~wptr_ff;
         if (do_pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push && (count_ff != 2'd2)) - 2'(do_pop);
      end
   end

   assign head           = entry_ff[rptr_ff];
   assign stat.not_empty = (count_ff != 2'd0);
   assign stat.full      = (count_ff == 2'd2);

endmodule

// ----- rtl/ppi_back.sv -----
// ----------------------------------------------------------------------------
// ppi_back
// Back part: origin numerators, 48-stage restoring divider per axis,
// saturation and the result register.
// ----------------------------------------------------------------------------
module ppi_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  ppi_pkg::ppi_item_type             item,
   output logic                              rsp_strobe,
   output logic                              rsp_line_valid,
   output logic signed [ppi_pkg::DirW-1:0]   rsp_dir_x,
   output logic signed [ppi_pkg::DirW-1:0]   rsp_dir_y,
   output logic signed [ppi_pkg::DirW-1:0]   rsp_dir_z,
   output logic signed [ppi_pkg::OrgW-1:0]   rsp_origin_x,
   output logic signed [ppi_pkg::OrgW-1:0]   rsp_origin_y,
   output logic signed [ppi_pkg::OrgW-1:0]   rsp_origin_z
);

   localparam int Steps = ppi_pkg::QuoW;

   // stage b1: numerator times normal component
   logic                               v1_ff;
   ppi_pkg::ppi_item_type              it1_ff;
   logic signed [ppi_pkg::ProdW-1:0]   pa_ff [3];
   logic signed [ppi_pkg::ProdW-1:0]   pb_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
      it1_ff   <= item;
      pa_ff[0] <= item.num0 * item.norm.ax;
      pa_ff[1] <= item.num0 * item.norm.ay;
      pa_ff[2] <= item.num0 * item.norm.az;
      pb_ff[0] <= item.num1 * item.norm.bx;
      pb_ff[1] <= item.num1 * item.norm.by;
      pb_ff[2] <= item.num1 * item.norm.bz;
   end

   // stage b2: sum, magnitude, scale and overflow check
   ppi_pkg::ppi_div_type  div_ff  [Steps+1][3];
   ppi_pkg::ppi_div_type  div_in  [Steps+1][3];
   ppi_pkg::ppi_side_type side_ff [Steps+1];

   for (genvar a = 0; a < 3; a++) begin : g_prep
      logic signed [ppi_pkg::ProdW-1:0] t;
      logic [ppi_pkg::ProdW-1:0]        mag;
      logic [ppi_pkg::ProdW+13:0]       m;
      always_comb begin
         t   = pa_ff[a] + pb_ff[a];
         mag = t[ppi_pkg::ProdW-1] ? ppi_pkg::ProdW'(-t) : ppi_pkg::ProdW'(t);
         m   = {mag, 14'd0};
         div_in[0][a].rem = 64'(m[ppi_pkg::ProdW+13:Steps]);
         div_in[0][a].num = m[Steps-1:0];
         div_in[0][a].quo = '0;
         div_in[0][a].neg = t[ppi_pkg::ProdW-1];
         div_in[0][a].ovf = 64'(m[ppi_pkg::ProdW+13:Steps]) >= it1_ff.det;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].vld <= 1'b0;
      end else begin
         side_ff[0].vld <= v1_ff;
      end
      side_ff[0].line  <= it1_ff.line;
      side_ff[0].dir_x <= it1_ff.dir_x;
      side_ff[0].dir_y <= it1_ff.dir_y;
      side_ff[0].dir_z <= it1_ff.dir_z;
      side_ff[0].det   <= it1_ff.det;
      div_ff[0]        <= div_in[0];
   end

   // divider stages: one quotient bit per stage
   for (genvar k = 0; k < Steps; k++) begin : g_div
      for (genvar a = 0; a < 3; a++) begin : g_ax
         logic [ppi_pkg::DetW:0] r2;
         logic                   ge;
         always_comb begin
            r2 = {div_ff[k][a].rem, div_ff[k][a].num[Steps-1]};
            ge = r2 >= {1'b0, side_ff[k].det};
            div_in[k+1][a].rem = ge ? 64'(r2 - {1'b0, side_ff[k].det}) : r2[63:0];
            div_in[k+1][a].num = {div_ff[k][a].num[Steps-2:0], 1'b0};
            div_in[k+1][a].quo = {div_ff[k][a].quo[Steps-2:0], ge};
            div_in[k+1][a].neg = div_ff[k][a].neg;
            div_in[k+1][a].ovf = div_ff[k][a].ovf;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k+1].vld <= 1'b0;
         end else begin
            side_ff[k+1].vld <= side_ff[k].vld;
         end
         side_ff[k+1].line  <= side_ff[k].line;
         side_ff[k+1].dir_x <= side_ff[k].dir_x;
         side_ff[k+1].dir_y <= side_ff[k].dir_y;
         side_ff[k+1].dir_z <= side_ff[k].dir_z;
         side_ff[k+1].det   <= side_ff[k].det;
         div_ff[k+1]        <= div_in[k+1];
      end
   end

   // result register: saturate, zero out parallel pairs
   logic                             strobe_ff, line_ff;
   logic signed [ppi_pkg::DirW-1:0]  dx_ff, dy_ff, dz_ff;
   logic signed [ppi_pkg::OrgW-1:0]  ox_ff, oy_ff, oz_ff;
   logic                             ln;

   assign ln = side_ff[Steps].line;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= side_ff[Steps].vld;
      end
      line_ff <= ln;
      dx_ff   <= ln ? side_ff[Steps].dir_x : '0;
      dy_ff   <= ln ? side_ff[Steps].dir_y : '0;
      dz_ff   <= ln ? side_ff[Steps].dir_z : '0;
      ox_ff   <= ln ? ppi_pkg::origin_sat(div_ff[Steps][0].neg, div_ff[Steps][0].ovf,
                                          div_ff[Steps][0].quo) : '0;
      oy_ff   <= ln ? ppi_pkg::origin_sat(div_ff[Steps][1].neg, div_ff[Steps][1].ovf,
                                          div_ff[Steps][1].quo) : '0;
      oz_ff   <= ln ? ppi_pkg::origin_sat(div_ff[Steps][2].neg, div_ff[Steps][2].ovf,
                                          div_ff[Steps][2].quo) : '0;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_line_valid = line_ff;
   assign rsp_dir_x      = dx_ff;
   assign rsp_dir_y      = dy_ff;
   assign rsp_dir_z      = dz_ff;
   assign rsp_origin_x   = ox_ff;
   assign rsp_origin_y   = oy_ff;
   assign rsp_origin_z   = oz_ff;

endmodule

// ----- rtl/plane_plane_intersection_unit.sv -----
// ----------------------------------------------------------------------------
// plane_plane_intersection_unit
// Line of intersection of two planes: direction, origin and parallel check.
// ----------------------------------------------------------------------------
// path: front stages, the queue, back stages b1 and b2, the divider and the result register
// throughput: one beat per cycle, set by the fully pipelined 48-stage divider
// busy rises only if the two-entry queue fills, which a free-running back never lets
// reset clears all valid bits; det_tolerance returns to 72057594 (1e-9 in Q56)
module plane_plane_intersection_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ppi_pkg::NormW-1:0]    req_normal_a_x,
   input  logic signed [ppi_pkg::NormW-1:0]    req_normal_a_y,
   input  logic signed [ppi_pkg::NormW-1:0]    req_normal_a_z,
   input  logic signed [ppi_pkg::OffW-1:0]     req_offset_a,
   input  logic signed [ppi_pkg::NormW-1:0]    req_normal_b_x,
   input  logic signed [ppi_pkg::NormW-1:0]    req_normal_b_y,
   input  logic signed [ppi_pkg::NormW-1:0]    req_normal_b_z,
   input  logic signed [ppi_pkg::OffW-1:0]     req_offset_b,
   output logic                                rsp_strobe,
   output logic                                rsp_line_valid,
   output logic signed [ppi_pkg::DirW-1:0]     rsp_dir_x,
   output logic signed [ppi_pkg::DirW-1:0]     rsp_dir_y,
   output logic signed [ppi_pkg::DirW-1:0]     rsp_dir_z,
   output logic signed [ppi_pkg::OrgW-1:0]     rsp_origin_x,
   output logic signed [ppi_pkg::OrgW-1:0]     rsp_origin_y,
   output logic signed [ppi_pkg::OrgW-1:0]     rsp_origin_z,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [3:0]                          paddr,
   input  logic [63:0]                         pwdata,
   output logic [63:0]                         prdata,
   output logic                                pready
);

   // configuration register
   logic [ppi_pkg::TolW-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= ppi_pkg::TolW'(72057594);
      end else if (psel && penable && pwrite && pready && !paddr[3]) begin
         tol_ff <= pwdata[ppi_pkg::TolW-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[3] ? 64'd0 : 64'(tol_ff);

   // front part
   ppi_pkg::ppi_norm_type   norm;
   ppi_pkg::ppi_item_type   f_item, q_head;
   ppi_pkg::ppi_q_stat_type q_stat;
   logic                    f_push, take;

   assign take    = start && !busy;
   assign norm.ax = req_normal_a_x;
   assign norm.ay = req_normal_a_y;
   assign norm.az = req_normal_a_z;
   assign norm.bx = req_normal_b_x;
   assign norm.by = req_normal_b_y;
   assign norm.bz = req_normal_b_z;

   ppi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .norm          (norm),
      .offset_a      (req_offset_a),
      .offset_b      (req_offset_b),
      .det_tolerance (tol_ff),
      .push          (f_push),
      .item          (f_item)
   );

   // queue between the parts
   ppi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .pop       (1'b1),
      .head      (q_head),
      .stat      (q_stat)
   );

   assign busy = q_stat.full;

   // back part
   ppi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .take           (q_stat.not_empty),
      .item           (q_head),
      .rsp_strobe     (rsp_strobe),
      .rsp_line_valid (rsp_line_valid),
      .rsp_dir_x      (rsp_dir_x),
      .rsp_dir_y      (rsp_dir_y),
      .rsp_dir_z      (rsp_dir_z),
      .rsp_origin_x   (rsp_origin_x),
      .rsp_origin_y   (rsp_origin_y),
      .rsp_origin_z   (rsp_origin_z)
   );

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(f_push && q_stat.full))
      else $error("queue overflow");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_line_valid) |-> (rsp_dir_x == '0 && rsp_dir_y == '0 &&
      rsp_dir_z == '0 && rsp_origin_x == '0 && rsp_origin_y == '0 && rsp_origin_z == '0))
      else $error("parallel result not zeroed");

   a_quiet_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_strobe)
      else $error("result beat right after reset");

endmodule
